/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable sorted-list priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DataW = 32;

  // Request kind carried on the input tuser bit
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // place the new entry, shift the tail back
    logic rem;  // shift the whole row toward the head
  } cell_ctl_t;

endpackage

/* hw/rtl/stable_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Priority queue kept sorted by ascending signed weight in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: tuser is the request kind (0 insert, 1 remove),
//   tdata carries value and weight. Every request yields one result on
//   m_axis: data_out, status and now_empty.
//   An insert goes behind all stored entries of equal or lower weight, so
//   equal weights leave in arrival order. A remove returns the head value.
//   An insert into a full queue is dropped with status FULL; a remove on an
//   empty queue returns zero data with status EMPTY.
// Timing:
//   One request per cycle while results are taken. Every cell compares
//   against the broadcast weight and shifts in the same cycle, so the
//   CAPACITY cells update together on an insert or remove. The result
//   appears in the cycle after acceptance, held in an output register.
// Reset and stall:
//   Reset empties the queue and drops any pending result. While the receiver
//   stalls, the output register holds its result and s_axis_tready drops, so
//   no request is accepted until the result is taken.
// ----------------------------------------------------------------------------
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] value, [63:32] weight
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] data_out, [33:32] status,
                                        // [34] now_empty, [39:35] zero
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                    req_fire;
  kind_e                   req_kind;
  logic signed [DataW-1:0] req_value;
  logic signed [DataW-1:0] req_weight;
  logic                    is_full;
  logic                    is_empty;
  cell_ctl_t               ctl;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  status_e         out_status_q, out_status_d;
  logic            out_empty_q, out_empty_d;

  logic                    occ    [CAPACITY];
  logic                    gt     [CAPACITY];
  logic signed [DataW-1:0] values [CAPACITY];
  logic signed [DataW-1:0] weights[CAPACITY];

  // Unpack request
  assign req_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign req_kind   = kind_e'(s_axis_tuser_i);
  assign req_value  = s_axis_tdata_i[DataW-1:0];
  assign req_weight = s_axis_tdata_i[2*DataW-1:DataW];

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Accept while the output slot is free or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  // Broadcast command to the row
  always_comb begin
    ctl.ins = req_fire && (req_kind == KIND_INSERT) && !is_full;
    ctl.rem = req_fire && (req_kind == KIND_REMOVE) && !is_empty;
  end

  // Row of cells, head at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_gt;
    logic signed [DataW-1:0] prev_value;
    logic signed [DataW-1:0] prev_weight;
    logic signed [DataW-1:0] next_value;
    logic signed [DataW-1:0] next_weight;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_gt     = 1'b0;
      assign prev_value  = '0;
      assign prev_weight = '0;
    end else begin : g_mid
      assign prev_gt     = gt[i-1];
      assign prev_value  = values[i-1];
      assign prev_weight = weights[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value  = '0;
      assign next_weight = '0;
    end else begin : g_body
      assign next_value  = values[i+1];
      assign next_weight = weights[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (occ[i]),
      .new_value_i   (req_value),
      .new_weight_i  (req_weight),
      .prev_gt_i     (prev_gt),
      .prev_value_i  (prev_value),
      .prev_weight_i (prev_weight),
      .next_value_i  (next_value),
      .next_weight_i (next_weight),
      .gt_o          (gt[i]),
      .value_o       (values[i]),
      .weight_o      (weights[i])
    );
  end

  // Advance fill count and build the result
  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_empty_d  = out_empty_q;
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CntW'(1);
    end
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (req_fire) begin
      out_valid_d  = 1'b1;
      out_data_d   = ctl.rem ? values[0] : '0;
      out_empty_d  = (count_d == '0);
      case (req_kind)
        KIND_INSERT: out_status_d = is_full ? ST_FULL : ST_OK;
        KIND_REMOVE: out_status_d = is_empty ? ST_EMPTY : ST_OK;
        default:     out_status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_empty_q  <= out_empty_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_empty_q, out_status_q, out_data_q};

endmodule

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a value and a weight, compares its weight
// against the incoming one and takes data from itself, a neighbor or the bus.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic                    occ_i,        // slot holds a live entry
  input  logic signed [DataW-1:0] new_value_i,
  input  logic signed [DataW-1:0] new_weight_i,
  input  logic                    prev_gt_i,    // neighbor toward head yields
  input  logic signed [DataW-1:0] prev_value_i,
  input  logic signed [DataW-1:0] prev_weight_i,
  input  logic signed [DataW-1:0] next_value_i,
  input  logic signed [DataW-1:0] next_weight_i,
  output logic                    gt_o,
  output logic signed [DataW-1:0] value_o,
  output logic signed [DataW-1:0] weight_o
);

  logic signed [DataW-1:0] value_q, value_d;
  logic signed [DataW-1:0] weight_q, weight_d;

  // Slot yields when empty or its weight is strictly above the new one
  assign gt_o = !occ_i || (weight_q > new_weight_i);

  // Select next slot contents
  always_comb begin
    value_d  = value_q;
    weight_d = weight_q;
    if (ctl_i.ins && gt_o) begin
      if (prev_gt_i) begin
        value_d  = prev_value_i;
        weight_d = prev_weight_i;
      end else begin
        value_d  = new_value_i;
        weight_d = new_weight_i;
      end
    end else if (ctl_i.rem) begin
      value_d  = next_value_i;
      weight_d = next_weight_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    weight_q <= weight_d;
  end

  assign value_o  = value_q;
  assign weight_o = weight_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for stable_priority_queue_core.
// A driver feeds insert and remove requests from a backlog, and a monitor
// predicts each result with a sorted-row model of its own. Every result is
// checked field by field in order. The run goes through idle and stall
// phases, and through one long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int HOLD_LEN     = 150;
  localparam int STALL_LIMIT  = 3000;
  localparam int ITEMS_PER_PH = 170;
  localparam int REPORT_MAX   = 10;

  // Directed inserts: extremes, equal weights, both signs
  localparam logic [31:0] SEED_WEIGHTS [16] = '{
    32'd0,          32'd5,          32'd5,          32'hffff_ffff,
    32'h8000_0000,  32'h7fff_ffff,  32'h7fff_ffff,  32'h8000_0000,
    32'd5,          32'hffff_fffb,  32'd0,          32'h7fff_ffff,
    32'h8000_0000,  32'd1,          32'd5,          32'hffff_ffff
  };
  localparam logic [31:0] SEED_VALUES [16] = '{
    32'h8000_0000,  32'h7fff_ffff,  32'h0000_0000,  32'hffff_ffff,
    32'h5555_5555,  32'haaaa_aaaa,  32'h0000_0001,  32'hfffffffe,
    32'h1234_5678,  32'h8765_4321,  32'h0f0f_0f0f,  32'hf0f0_f0f0,
    32'h0000_00ff,  32'hff00_0000,  32'h3c3c_3c3c,  32'hc3c3_c3c3
  };

  typedef struct {
    kind_e       kind;
    logic [31:0] value;
    logic [31:0] weight;
  } request_t;

  typedef struct {
    logic [31:0] data_out;
    status_e     status;
    logic        now_empty;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // [31:0] value, [63:32] weight
  logic        s_axis_tuser_i;   // [0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // [31:0] data_out, [33:32] status,
                                 // [34] now_empty, [39:35] zero

  stable_priority_queue_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  request_t    request_backlog[$];
  outcome_t    predicted_outcomes[$];
  request_t    drive_req;

  // Shadow of the block's sorted row
  logic [31:0] row_value [CAPACITY];
  logic [31:0] row_weight[CAPACITY];
  int          row_count;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_asks;
  int          hold_served;
  int          hold_left;
  int          quiet_cycles;
  logic        req_taken;

  int          mismatches;
  int          results_checked;
  int          inserts_seen;
  int          removes_seen;
  int          full_drops;
  int          empty_removes;

  // Apply one request to the shadow row and return the result it must give
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       pos;
    o.data_out  = '0;
    o.status    = ST_OK;
    if (r.kind == KIND_INSERT) begin
      inserts_seen++;
      if (row_count >= CAPACITY) begin
        o.status = ST_FULL;
        full_drops++;
      end else begin
        pos = 0;
        // go behind every entry of equal or lower weight
        while (pos < row_count && $signed(row_weight[pos]) <= $signed(r.weight))
          pos++;
        for (int k = row_count; k > pos; k--) begin
          row_value[k]  = row_value[k-1];
          row_weight[k] = row_weight[k-1];
        end
        row_value[pos]  = r.value;
        row_weight[pos] = r.weight;
        row_count++;
      end
    end else begin
      removes_seen++;
      if (row_count == 0) begin
        o.status = ST_EMPTY;
        empty_removes++;
      end else begin
        o.data_out = row_value[0];
        for (int k = 1; k < row_count; k++) begin
          row_value[k-1]  = row_value[k];
          row_weight[k-1] = row_weight[k];
        end
        row_count--;
      end
    end
    o.now_empty = (row_count == 0);
    return o;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Compare one accepted result with the oldest prediction
  function automatic void check_result(logic [39:0] word);
    outcome_t want;
    results_checked++;
    if (predicted_outcomes.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing expected", word));
    end else begin
      want = predicted_outcomes.pop_front();
      if (word[31:0] !== want.data_out)
        flag_mismatch($sformatf("data_out expected %h got %h", want.data_out, word[31:0]));
      if (word[33:32] !== want.status)
        flag_mismatch($sformatf("status expected %0d got %0d", want.status, word[33:32]));
      if (word[34] !== want.now_empty)
        flag_mismatch($sformatf("now_empty expected %b got %b", want.now_empty, word[34]));
      if (word[39:35] !== 5'd0)
        flag_mismatch($sformatf("pad bits expected 0 got %b", word[39:35]));
    end
  endfunction

  // Queue one request
  task automatic queue_request(kind_e kind, logic [31:0] value, logic [31:0] weight);
    request_t r;
    r.kind   = kind;
    r.value  = value;
    r.weight = weight;
    request_backlog.push_back(r);
  endtask

  function automatic logic [31:0] pick_weight();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50)
      return 32'($signed($urandom_range(7)) - 4);
    else if (roll < 80)
      return $urandom;
    else if (roll < 90)
      return 32'h8000_0000;
    else
      return 32'h7fff_ffff;
  endfunction

  // Random traffic in fill and drain trends so the row runs full and empty
  task automatic queue_random_burst(int count);
    bit trend_fill;
    int ins_pct;
    trend_fill = 1'($urandom_range(1));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0)
        trend_fill = !trend_fill;
      ins_pct = trend_fill ? 75 : 30;
      if ($urandom_range(99) < ins_pct)
        queue_request(KIND_INSERT, $urandom, pick_weight());
      else
        queue_request(KIND_REMOVE, $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || s_axis_tvalid_i || predicted_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Sender: offer the next request once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || req_taken)) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = request_backlog.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= drive_req.kind;
        s_axis_tdata_i  <= {drive_req.weight, drive_req.value};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and hold off fully during a pressure window
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // Count down the receiver hold-off window
  always @(posedge clk_i) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check results, then predict for the request taken this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i)
        check_result(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o)
        predicted_outcomes.push_back(apply_request('{
          kind:   kind_e'(s_axis_tuser_i),
          value:  s_axis_tdata_i[31:0],
          weight: s_axis_tdata_i[63:32]}));
    end
  end

  // Watchdog: end the run when work is pending and nothing moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (request_backlog.size() == 0 && !s_axis_tvalid_i && predicted_outcomes.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    req_taken       = 1'b0;
    row_count       = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_asks       = 0;
    hold_served     = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    mismatches      = 0;
    results_checked = 0;
    inserts_seen    = 0;
    removes_seen    = 0;
    full_drops      = 0;
    empty_removes   = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: remove on empty, fill with extremes and ties, overflow, drain a few
    queue_request(KIND_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
    for (int k = 0; k < 16; k++)
      queue_request(KIND_INSERT, SEED_VALUES[k], SEED_WEIGHTS[k]);
    queue_request(KIND_INSERT, 32'hdead_beef, 32'h8000_0000);
    queue_request(KIND_INSERT, 32'hcafe_f00d, 32'h7fff_ffff);
    for (int k = 0; k < 4; k++)
      queue_request(KIND_REMOVE, 32'd0, 32'd0);
    // Hold the receiver while the sender keeps offering
    @(posedge clk_i);
    hold_asks = hold_asks + 1;
    wait_drained();

    // Phase: no idling on either side
    queue_random_burst(ITEMS_PER_PH);
    wait_drained();

    // Phase: sender mostly idle
    send_idle_pct = 86;
    queue_random_burst(ITEMS_PER_PH);
    wait_drained();

    // Phase: receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    queue_random_burst(ITEMS_PER_PH);
    wait_drained();

    // Phase: both sides idle now and then
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    queue_random_burst(ITEMS_PER_PH);
    wait_drained();

    // Let any stray result show up
    repeat (20) @(posedge clk_i);

    $display("Covered %0d inserts and %0d removes, %0d results checked.",
             inserts_seen, removes_seen, results_checked);
    $display("Full-queue drops: %0d, removes on empty: %0d, mismatches: %0d.",
             full_drops, empty_removes, mismatches);
    if (mismatches == 0 && predicted_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
